// File: design/port_range_allocator_lru_macros.svh
// ----------------------------------------------------------------------------
// Port range allocator assertion macros
// Shared concurrent assertion forms for the allocator modules.
// ----------------------------------------------------------------------------
`ifndef PORT_RANGE_ALLOCATOR_LRU_MACROS_SVH
`define PORT_RANGE_ALLOCATOR_LRU_MACROS_SVH

// Same-cycle implication, checked at every edge outside reset.
`define PRAL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every edge outside reset.
`define PRAL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/pral_pkg.sv
// ----------------------------------------------------------------------------
// Port range allocator package
// Sizes, codes and control types shared by the allocator modules.
// ----------------------------------------------------------------------------
package pral_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int PORT_W     = 16;
    localparam int FRESH_W    = PORT_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int STATUS_W   = 2;

    localparam logic [PORT_W-1:0] RANGE_LOW_RST  = 16'd0;
    localparam logic [PORT_W-1:0] RANGE_HIGH_RST = 16'd1023;

    typedef logic [PORT_W-1:0]    port_t;
    typedef logic [FRESH_W-1:0]   fresh_t;
    typedef logic [RING_AW-1:0]   ring_idx_t;
    typedef logic [CNT_W-1:0]     ring_cnt_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [STATUS_W-1:0]  status_t;

    // Request commands
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Register indexes
    localparam cfg_idx_t CFG_RANGE_LOW  = 2'd0;
    localparam cfg_idx_t CFG_RANGE_HIGH = 2'd1;

    // Result status codes
    localparam status_t STATUS_GRANTED  = 2'd0;
    localparam status_t STATUS_NONE     = 2'd1;
    localparam status_t STATUS_RELEASED = 2'd2;
    localparam status_t STATUS_DROPPED  = 2'd3;

    // Operation chosen for an accepted item
    typedef enum logic [2:0] {
        OP_FRESH,
        OP_POP,
        OP_PUSH,
        OP_NONE,
        OP_DROP
    } op_t;

    typedef struct packed {
        logic take;
        op_t  op;
        logic pop_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic fresh_avail;
        logic ring_empty;
        logic ring_full;
        logic out_free;
    } dp_stat_t;

endpackage

// File: design/port_range_allocator_lru.sv
// ----------------------------------------------------------------------------
// Port range allocator with least-recently-released reuse
// Hands out numbers from [range_low, range_high], then recycles released ones.
// ----------------------------------------------------------------------------
// An allocate item returns never-used numbers in rising order from range_low;
// once those run out it returns the oldest number in a ring of released
// numbers (RING_DEPTH entries), or status "none available" if the ring is
// empty. A release item appends its number to the ring, or is dropped with
// status "dropped" if the ring is full. Every item yields exactly one result.
// Fresh grants, releases, drops and "none available" are written straight to
// the result register; a grant from the ring first passes the ring memory's
// registered read port. A new item enters only in the idle state, when the
// result register is empty or its result leaves at the same edge; a stalled
// result holds the input stalled too. Writing range_low or range_high restarts
// the allocator (ring emptied); write the registers only while no item is in
// flight. cfg_ready is always high. Ring contents need no clearing after reset.
// ----------------------------------------------------------------------------
module port_range_allocator_lru (
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  pral_pkg::port_t    port,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output pral_pkg::port_t    granted,
    output pral_pkg::status_t  status,
    // register write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  pral_pkg::cfg_idx_t cfg_index,
    input  pral_pkg::port_t    cfg_data
);
    import pral_pkg::*;

    ctl_cmd_t ctl;
    dp_stat_t stat;

    // Always take register writes; keep them to times with no item in flight
    assign cfg_ready = 1'b1;

    pral_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat),
        .ctl      (ctl)
    );

    pral_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .port      (port),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .granted   (granted),
        .status    (status)
    );

endmodule

// File: design/pral_datapath.sv
// ----------------------------------------------------------------------------
// Port range allocator datapath
// Range registers, fresh counter, released-number ring and result register.
// ----------------------------------------------------------------------------
`include "port_range_allocator_lru_macros.svh"

module pral_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  pral_pkg::ctl_cmd_t ctl,
    output pral_pkg::dp_stat_t stat,
    input  pral_pkg::port_t    port,
    input  logic               cfg_we,
    input  pral_pkg::cfg_idx_t cfg_index,
    input  pral_pkg::port_t    cfg_data,
    output logic               out_valid,
    input  logic               out_stall,
    output pral_pkg::port_t    granted,
    output pral_pkg::status_t  status
);
    import pral_pkg::*;

    port_t     range_low_reg, range_low_next;
    port_t     range_high_reg, range_high_next;
    fresh_t    next_fresh_reg, next_fresh_next;
    ring_idx_t ring_head_reg, ring_head_next;
    ring_idx_t ring_tail_reg, ring_tail_next;
    ring_cnt_t ring_count_reg, ring_count_next;
    logic      out_valid_reg, out_valid_next;
    port_t     granted_reg, granted_next;
    status_t   status_reg, status_next;
    port_t     rd_data_reg;
    port_t     ring_mem [RING_DEPTH];
    logic      restart;
    logic      wr_en;
    logic      rd_en;

    function automatic ring_idx_t ring_adv(input ring_idx_t idx);
        ring_idx_t r;
        if (idx == RING_AW'(RING_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = idx + 1'b1;
        end
        return r;
    endfunction

    assign stat.fresh_avail = (next_fresh_reg <= {1'b0, range_high_reg});
    assign stat.ring_empty  = (ring_count_reg == '0);
    assign stat.ring_full   = (ring_count_reg == CNT_W'(RING_DEPTH));
    assign stat.out_free    = !out_valid_reg || !out_stall;

    assign restart = cfg_we && (cfg_index == CFG_RANGE_LOW || cfg_index == CFG_RANGE_HIGH);
    assign wr_en   = ctl.take && (ctl.op == OP_PUSH);
    assign rd_en   = ctl.take && (ctl.op == OP_POP);

    always_comb
    begin
        range_low_next  = range_low_reg;
        range_high_next = range_high_reg;
        next_fresh_next = next_fresh_reg;
        ring_head_next  = ring_head_reg;
        ring_tail_next  = ring_tail_reg;
        ring_count_next = ring_count_reg;
        if (restart) begin
            if (cfg_index == CFG_RANGE_LOW) begin
                range_low_next = cfg_data;
            end else begin
                range_high_next = cfg_data;
            end
            next_fresh_next = {1'b0, range_low_next};
            ring_head_next  = '0;
            ring_tail_next  = '0;
            ring_count_next = '0;
        end else if (ctl.take) begin
            unique case (ctl.op)
                OP_FRESH: next_fresh_next = next_fresh_reg + 1'b1;
                OP_POP:
                begin
                    ring_head_next  = ring_adv(ring_head_reg);
                    ring_count_next = ring_count_reg - 1'b1;
                end
                OP_PUSH:
                begin
                    ring_tail_next  = ring_adv(ring_tail_reg);
                    ring_count_next = ring_count_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        granted_next   = granted_reg;
        status_next    = status_reg;
        if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end
        if (ctl.pop_load) begin
            out_valid_next = 1'b1;
            granted_next   = rd_data_reg;
            status_next    = STATUS_GRANTED;
        end else if (ctl.take && ctl.op != OP_POP) begin
            out_valid_next = 1'b1;
            granted_next   = '0;
            unique case (ctl.op)
                OP_FRESH:
                begin
                    granted_next = next_fresh_reg[PORT_W-1:0];
                    status_next  = STATUS_GRANTED;
                end
                OP_PUSH: status_next = STATUS_RELEASED;
                OP_DROP: status_next = STATUS_DROPPED;
                default: status_next = STATUS_NONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            range_low_reg  <= RANGE_LOW_RST;
            range_high_reg <= RANGE_HIGH_RST;
            next_fresh_reg <= {1'b0, RANGE_LOW_RST};
            ring_head_reg  <= '0;
            ring_tail_reg  <= '0;
            ring_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            range_low_reg  <= range_low_next;
            range_high_reg <= range_high_next;
            next_fresh_reg <= next_fresh_next;
            ring_head_reg  <= ring_head_next;
            ring_tail_reg  <= ring_tail_next;
            ring_count_reg <= ring_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

    // Ring memory: one write port at the tail, registered read at the head
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            ring_mem[ring_tail_reg] <= port;
        end
        if (rd_en) begin
            rd_data_reg <= ring_mem[ring_head_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign granted   = granted_reg;
    assign status    = status_reg;

    `PRAL_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1,
        ring_count_reg <= CNT_W'(RING_DEPTH), "ring count above depth")
    `PRAL_ASSERT_NXT(a_push_count, clk, rst_n, wr_en && !restart,
        ring_count_reg == $past(ring_count_reg) + 1'b1, "push did not grow ring")
    `PRAL_ASSERT_IMP(a_none_empty, clk, rst_n, out_valid_reg && status_reg == STATUS_NONE,
        granted_reg == '0, "none-available result carries a number")

endmodule

// File: design/pral_ctrl.sv
// ----------------------------------------------------------------------------
// Port range allocator controller
// Accepts requests, picks the operation and sequences ring reads.
// ----------------------------------------------------------------------------
`include "port_range_allocator_lru_macros.svh"

module pral_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  pral_pkg::dp_stat_t stat,
    output pral_pkg::ctl_cmd_t ctl
);
    import pral_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_POP  = 2'b10
    } state_t;

    state_t state_reg, state_next;
    op_t    op;

    always_comb
    begin
        if (cmd == CMD_ALLOC) begin
            priority if (stat.fresh_avail) begin
                op = OP_FRESH;
            end else if (!stat.ring_empty) begin
                op = OP_POP;
            end else begin
                op = OP_NONE;
            end
        end else begin
            op = stat.ring_full ? OP_DROP : OP_PUSH;
        end
    end

    assign in_stall     = !((state_reg == ST_IDLE) && stat.out_free);
    assign ctl.take     = in_valid && !in_stall;
    assign ctl.op       = op;
    assign ctl.pop_load = (state_reg == ST_POP);

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: state_next = (ctl.take && op == OP_POP) ? ST_POP : ST_IDLE;
            ST_POP:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `PRAL_ASSERT_NXT(a_pop_enter, clk, rst_n, ctl.take && op == OP_POP,
        state_reg == ST_POP, "ring pop did not enter read state")
    `PRAL_ASSERT_NXT(a_pop_leave, clk, rst_n, state_reg == ST_POP,
        state_reg == ST_IDLE, "read state held past one cycle")
    `PRAL_ASSERT_IMP(a_pop_nonempty, clk, rst_n, ctl.take && op == OP_POP,
        !stat.fresh_avail && !stat.ring_empty, "pop chosen without ring entry")

endmodule

// File: sim/tb_port_range_allocator_lru.sv
// ----------------------------------------------------------------------------
// Port range allocator testbench
// Drives allocate and release requests with random gaps and result stalls
// against a cycle-free model of the allocator. Covers default, extreme, empty
// and small ranges, a ring filled past capacity, and writes to unused indexes.
// ----------------------------------------------------------------------------
module tb_port_range_allocator_lru;
    timeunit 1ns;
    timeprecision 1ps;

    import pral_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_LIMIT = 10;

    // Indexes with no register behind them; a write there must do nothing.
    localparam cfg_idx_t CFG_SPARE_2 = 2'd2;
    localparam cfg_idx_t CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic  op;
        port_t num;
    } request_t;

    typedef struct packed {
        port_t   granted;
        status_t status;
    } alloc_result_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    logic     cmd = CMD_ALLOC;
    port_t    port = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    port_t    granted;
    status_t  status;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    cfg_idx_t cfg_index = CFG_RANGE_LOW;
    port_t    cfg_data = '0;

    // Allocator shadow state, advanced once per accepted item
    port_t     lo_bound = RANGE_LOW_RST;
    port_t     hi_bound = RANGE_HIGH_RST;
    fresh_t    fresh_next = fresh_t'(RANGE_LOW_RST);
    port_t     recycle_ring [RING_DEPTH];
    ring_idx_t ring_rd = '0;
    ring_idx_t ring_wr = '0;
    ring_cnt_t ring_fill = '0;

    request_t      pending_requests [$];
    alloc_result_t expected_results [$];

    int gap_left = 0;
    int stall_left = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    bit steady = 1'b0;

    port_range_allocator_lru dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .port      (port),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .granted   (granted),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow allocator
    // ------------------------------------------------------------------------

    function automatic ring_idx_t step_index(ring_idx_t idx);
        return (idx == ring_idx_t'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    // Apply a register write; either range register restarts the allocator.
    function automatic void apply_register(cfg_idx_t idx, port_t data);
        if (idx == CFG_RANGE_LOW || idx == CFG_RANGE_HIGH)
        begin
            if (idx == CFG_RANGE_LOW)
                lo_bound = data;
            else
                hi_bound = data;
            fresh_next = fresh_t'(lo_bound);
            ring_rd = '0;
            ring_wr = '0;
            ring_fill = '0;
        end
    endfunction

    // Serve one request: fresh numbers first, then the oldest released one.
    function automatic alloc_result_t serve_request(logic op, port_t num);
        alloc_result_t res;
        res.granted = '0;
        if (op == CMD_ALLOC)
        begin
            if (fresh_next <= fresh_t'(hi_bound))
            begin
                res.granted = fresh_next[PORT_W-1:0];
                fresh_next = fresh_next + 1'b1;
                res.status = STATUS_GRANTED;
            end
            else if (ring_fill != '0)
            begin
                res.granted = recycle_ring[ring_rd];
                ring_rd = step_index(ring_rd);
                ring_fill = ring_fill - 1'b1;
                res.status = STATUS_GRANTED;
            end
            else
                res.status = STATUS_NONE;
        end
        else if (ring_fill == ring_cnt_t'(RING_DEPTH))
            res.status = STATUS_DROPPED;
        else
        begin
            recycle_ring[ring_wr] = num;
            ring_wr = step_index(ring_wr);
            ring_fill = ring_fill + 1'b1;
            res.status = STATUS_RELEASED;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------

    // Mostly a short pause, now and then a long one.
    function automatic int pick_pause();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Bias released numbers toward the live range, with extremes and noise.
    function automatic port_t pick_port();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50 && lo_bound <= hi_bound)
            return lo_bound + port_t'($urandom_range(0, int'(hi_bound) - int'(lo_bound)));
        if (roll < 60)
            return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        return port_t'($urandom);
    endfunction

    task automatic note_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%s", msg);
    endtask

    task automatic push_request(logic op, port_t num);
        request_t req;
        req.op = op;
        req.num = num;
        pending_requests.push_back(req);
    endtask

    // Queue n random requests, alloc_pct percent of them allocates.
    task automatic queue_mix(int n, int alloc_pct);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < alloc_pct)
                push_request(CMD_ALLOC, port_t'($urandom));
            else
                push_request(CMD_RELEASE, pick_port());
        end
    endtask

    // Write one register through the handshake and mirror it in the shadow.
    task automatic write_register(cfg_idx_t idx, port_t data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_register(idx, data);
        cfg_valid <= 1'b0;
    endtask

    // Block until every queued item is taken and every result checked.
    task automatic drain();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Pick the idle mode for the next phase: about one in four runs flat out.
    task automatic begin_phase();
        @(negedge clk);
        steady = ($urandom_range(0, 3) == 0);
    endtask

    // ------------------------------------------------------------------------
    // Request driver: present the queue head, hold it while stalled, and
    // predict the result at the edge that accepts it.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        request_t req;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd <= CMD_ALLOC;
            port <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(serve_request(cmd, port));
            // A stalled item stays on the wires untouched.
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    req = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    cmd <= req.op;
                    port <= req.num;
                    // The pause counts down after this item is taken.
                    if (!steady && $urandom_range(0, 99) < 30)
                        gap_left <= pick_pause();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: check each accepted result against the oldest
    // prediction, and stall the result channel at random.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    note_failure($sformatf("unexpected result: granted=%0d status=%0d",
                                           granted, status));
                else
                begin
                    want = expected_results.pop_front();
                    if (granted !== want.granted || status !== want.status)
                        note_failure($sformatf(
                            "result mismatch: expected granted=%0d status=%0d, got granted=%0d status=%0d",
                            want.granted, want.status, granted, status));
                end
            end
            if (steady)
            begin
                out_stall <= 1'b0;
                stall_left <= 0;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if ($urandom_range(0, 99) < 25)
            begin
                out_stall <= 1'b1;
                stall_left <= pick_pause() - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Give up on a hung block.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("port_range_allocator_lru test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        port_t lo;
        port_t hi;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset range 0..1023: plenty of fresh numbers, releases pile up.
        begin_phase();
        queue_mix(150, 60);
        drain();

        // Top of the port space: two fresh numbers, then exhaustion and the
        // ring handing back releases oldest first.
        write_register(CFG_RANGE_LOW, 16'hFFFE);
        write_register(CFG_RANGE_HIGH, 16'hFFFF);
        begin_phase();
        push_request(CMD_ALLOC, 16'h0000);
        push_request(CMD_ALLOC, 16'hFFFF);
        push_request(CMD_ALLOC, 16'h0000);
        push_request(CMD_RELEASE, 16'h0000);
        push_request(CMD_RELEASE, 16'hFFFF);
        push_request(CMD_RELEASE, 16'hA5A5);
        push_request(CMD_ALLOC, 16'hFFFF);
        push_request(CMD_ALLOC, 16'h0000);
        push_request(CMD_ALLOC, 16'h5A5A);
        push_request(CMD_ALLOC, 16'h0000);
        drain();

        // Empty range: only released numbers can be granted. Writes to the
        // spare indexes must leave the ring contents alone.
        write_register(CFG_RANGE_LOW, 16'hFFFF);
        write_register(CFG_RANGE_HIGH, 16'h0000);
        begin_phase();
        push_request(CMD_ALLOC, 16'h0000);
        push_request(CMD_RELEASE, 16'h1234);
        push_request(CMD_RELEASE, 16'hFFFF);
        drain();
        write_register(CFG_SPARE_2, 16'hFFFF);
        write_register(CFG_SPARE_3, 16'h0000);
        begin_phase();
        push_request(CMD_ALLOC, 16'h0000);
        push_request(CMD_ALLOC, 16'h0000);
        push_request(CMD_ALLOC, 16'h0000);
        drain();

        // Fill the ring past capacity so the tail wraps and releases drop,
        // then mix in allocates that pull from the full ring.
        write_register(CFG_RANGE_HIGH, 16'h0000);
        write_register(CFG_RANGE_LOW, 16'h0001);
        begin_phase();
        queue_mix(RING_DEPTH + 6, 0);
        queue_mix(24, 60);
        drain();

        // Whole port space as the range.
        write_register(CFG_RANGE_LOW, 16'h0000);
        write_register(CFG_RANGE_HIGH, 16'hFFFF);
        begin_phase();
        queue_mix(60, 55);
        drain();

        // Small random ranges: fresh numbers run out early and the ring churns.
        for (int p = 0; p < 5; p++)
        begin
            lo = port_t'($urandom_range(0, 16'hFFFF - 16));
            hi = lo + port_t'($urandom_range(0, 15));
            if (p % 2 == 0)
            begin
                write_register(CFG_RANGE_LOW, lo);
                write_register(CFG_RANGE_HIGH, hi);
            end
            else
            begin
                write_register(CFG_RANGE_HIGH, hi);
                write_register(CFG_RANGE_LOW, lo);
            end
            begin_phase();
            queue_mix(60, 55);
            drain();
        end

        // Random inverted range.
        hi = port_t'($urandom_range(0, 16'h7FFF));
        lo = hi + port_t'($urandom_range(1, 16'h7FFF));
        write_register(CFG_RANGE_LOW, lo);
        write_register(CFG_RANGE_HIGH, hi);
        begin_phase();
        queue_mix(60, 50);
        drain();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_results.size()));
        if (mismatch_count == 0)
            $display("port_range_allocator_lru test passed");
        else
            $display("port_range_allocator_lru test failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/pral_pkg.sv
design/pral_datapath.sv
design/pral_ctrl.sv
design/port_range_allocator_lru.sv
sim/tb_port_range_allocator_lru.sv
